/* hw/rtl/erskip_pkg.sv */
package erskip_pkg;

    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 32;
    localparam int NUMV_BITS      = 21;
    localparam int FRAC_BITS      = 32;

    localparam logic [CFG_INDEX_BITS-1:0] REG_NUM_VERTICES     = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_EDGE_PROBABILITY = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SKIP_SCALE       = 2'd2;

    localparam logic OP_CONSUME = 1'b0;
    localparam logic OP_RESTART = 1'b1;

    // ln 2 as Q0.32, rounded
    localparam logic [31:0] LN2_Q32 = 32'd2977044472;
    localparam logic [31:0] SKIP_SCALE_RESET = 32'd65536;

    localparam int LOG_STEPS = 24;

    typedef enum logic [2:0] {
        F_IDLE,
        F_NORM,
        F_SQR,
        F_LN,
        F_LNRND,
        F_SCALE,
        F_ROUND,
        F_PUSH
    } front_state_t;

    typedef enum logic {
        B_IDLE,
        B_WALK
    } back_state_t;

endpackage

/* hw/rtl/erskip_sample_if.sv */
interface erskip_sample_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic [31:0] random_fraction;

    modport source (output valid, operation, random_fraction, input ready);
    modport sink (input valid, operation, random_fraction, output ready);
endinterface

/* hw/rtl/erskip_result_if.sv */
interface erskip_result_if #(parameter int VERTEX_BITS = 20);
    logic                   valid;
    logic                   ready;
    logic [VERTEX_BITS-1:0] source_vertex;
    logic [VERTEX_BITS-1:0] target_vertex;
    logic                   edge_found;
    logic                   done_res;

    modport source (output valid, source_vertex, target_vertex, edge_found, done_res,
                    input ready);
    modport sink (input valid, source_vertex, target_vertex, edge_found, done_res,
                  output ready);
endinterface

/* hw/rtl/erskip_front.sv */
module erskip_front #(
    parameter int SKIP_BITS = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    erskip_sample_if.sink         sample,
    input  logic [31:0]           edge_probability,
    input  logic [31:0]           skip_scale,
    output logic                  push_valid,
    input  logic                  push_ready,
    output logic                  push_restart,
    output logic [SKIP_BITS-1:0]  push_skip
);
    import erskip_pkg::*;

    localparam int SW = 22;
    localparam int CW = (SKIP_BITS > SW) ? SKIP_BITS : SW;

    front_state_t         state_reg, state_next;
    logic [31:0]          m_reg, m_next;
    logic [4:0]           e_reg, e_next;
    logic [4:0]           step_reg, step_next;
    logic [23:0]          frac_reg, frac_next;
    logic [61:0]          prod_reg, prod_next;
    logic [28:0]          ln_reg, ln_next;
    logic                 restart_reg, restart_next;
    logic [SKIP_BITS-1:0] skip_reg, skip_next;

    logic                 accept;
    logic                 short_skip;
    logic [63:0]          sq;
    logic [32:0]          sq_top;
    logic [29:0]          lg;
    logic [61:0]          ln_sum;
    logic [SW-1:0]        s_val;
    logic [CW-1:0]        s_ext;
    logic [CW-1:0]        s_max;

    assign accept     = sample.valid && sample.ready;
    assign short_skip = (sample.random_fraction < edge_probability)
                        || (sample.random_fraction == '0);
    assign sq         = 64'(m_reg) * 64'(m_reg);
    assign sq_top     = sq[63:31];
    assign lg         = (30'(6'd32 - 6'(e_reg)) << 24) - 30'(frac_reg);
    assign ln_sum     = prod_reg + 62'(33'h080000000);
    assign s_val      = SW'(prod_reg[60:40]) + SW'(|prod_reg[39:0]);
    assign s_ext      = CW'(s_val);
    assign s_max      = CW'({SKIP_BITS{1'b1}});

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    if (sample.operation == OP_RESTART || short_skip)
                        state_next = F_PUSH;
                    else
                        state_next = F_NORM;
                end
            end
            F_NORM:  if (m_reg[31]) state_next = F_SQR;
            F_SQR:   if (step_reg == 5'(LOG_STEPS - 1)) state_next = F_LN;
            F_LN:    state_next = F_LNRND;
            F_LNRND: state_next = F_SCALE;
            F_SCALE: state_next = F_ROUND;
            F_ROUND: state_next = F_PUSH;
            F_PUSH:  if (push_ready) state_next = F_IDLE;
            default: state_next = F_IDLE;
        endcase
    end

    always_comb
    begin
        sample.ready = (state_reg == F_IDLE);
        push_valid   = (state_reg == F_PUSH);
        push_restart = restart_reg;
        push_skip    = skip_reg;
    end

    always_comb
    begin
        m_next       = m_reg;
        e_next       = e_reg;
        step_next    = step_reg;
        frac_next    = frac_reg;
        prod_next    = prod_reg;
        ln_next      = ln_reg;
        restart_next = restart_reg;
        skip_next    = skip_reg;
        case (state_reg)
            F_IDLE:
            begin
                restart_next = (sample.operation == OP_RESTART);
                skip_next    = SKIP_BITS'(1);
                m_next       = 32'(~sample.random_fraction) + 32'd1;
                e_next       = 5'd31;
                step_next    = '0;
                frac_next    = '0;
            end
            F_NORM:
            begin
                if (!m_reg[31])
                begin
                    m_next = {m_reg[30:0], 1'b0};
                    e_next = e_reg - 5'd1;
                end
            end
            F_SQR:
            begin
                frac_next = {frac_reg[22:0], sq_top[32]};
                m_next    = sq_top[32] ? sq_top[32:1] : sq_top[31:0];
                step_next = step_reg + 5'd1;
            end
            F_LN:    prod_next = 62'(lg) * 62'(LN2_Q32);
            F_LNRND: ln_next = ln_sum[60:32];
            F_SCALE: prod_next = 62'(ln_reg) * 62'(skip_scale);
            F_ROUND:
            begin
                if (s_val == '0)
                    skip_next = SKIP_BITS'(1);
                else if (s_ext > s_max)
                    skip_next = SKIP_BITS'(s_max);
                else
                    skip_next = SKIP_BITS'(s_ext);
            end
            F_PUSH: ;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= F_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        m_reg       <= m_next;
        e_reg       <= e_next;
        step_reg    <= step_next;
        frac_reg    <= frac_next;
        prod_reg    <= prod_next;
        ln_reg      <= ln_next;
        restart_reg <= restart_next;
        skip_reg    <= skip_next;
    end

    a_push_skip_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (push_valid && !push_restart) |-> (push_skip != '0))
        else $error("zero skip pushed");
    a_norm_top_bit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == F_SQR) |-> m_reg[31])
        else $error("mantissa not normalised during squaring");
    a_push_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (push_valid && !push_ready) |=> (push_valid && $stable(push_skip)))
        else $error("queued skip changed before taken");

endmodule

/* hw/rtl/erskip_queue.sv */
module erskip_queue #(
    parameter int WIDTH = 33
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_valid,
    output logic             wr_ready,
    input  logic [WIDTH-1:0] wr_data,
    output logic             rd_valid,
    input  logic             rd_ready,
    output logic [WIDTH-1:0] rd_data
);
    logic [WIDTH-1:0] slot_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg, count_next;
    logic             do_wr, do_rd;

    assign wr_ready = (count_reg != 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_data  = slot_reg[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_wr;
        rd_ptr_next = rd_ptr_reg ^ do_rd;
        count_next  = count_reg + 2'(do_wr) - 2'(do_rd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            slot_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

/* hw/rtl/erskip_back.sv */
module erskip_back #(
    parameter int VERTEX_BITS = 20,
    parameter int SKIP_BITS   = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_valid,
    output logic                          q_ready,
    input  logic                          q_restart,
    input  logic [SKIP_BITS-1:0]          q_skip,
    input  logic [erskip_pkg::NUMV_BITS-1:0] num_vertices,
    erskip_result_if.source               result
);
    import erskip_pkg::*;

    localparam int VB  = VERTEX_BITS;
    localparam int NCW = (VB + 1 > NUMV_BITS) ? VB + 1 : NUMV_BITS;
    localparam int CW  = (VB > SKIP_BITS) ? VB : SKIP_BITS;

    back_state_t          state_reg, state_next;
    logic [VB-1:0]        row_reg, row_next;
    logic [VB-1:0]        col_reg, col_next;
    logic                 finished_reg, finished_next;
    logic [SKIP_BITS-1:0] incr_reg, incr_next;
    logic                 out_valid_reg, out_valid_next;
    logic [VB-1:0]        src_reg, src_next;
    logic [VB-1:0]        tgt_reg, tgt_next;
    logic                 edge_reg, edge_next;
    logic                 done_reg, done_next;

    logic [NCW-1:0]       n_ext, n_cap, n_use;
    logic [VB-1:0]        last;
    logic [VB-1:0]        room;
    logic [VB-1:0]        col_hop;
    logic                 active;
    logic                 free;
    logic                 fits;

    assign n_ext   = NCW'(num_vertices);
    assign n_cap   = NCW'(1) << VB;
    assign n_use   = (n_ext > n_cap) ? n_cap : n_ext;
    assign last    = (n_use == '0) ? '0 : VB'(n_use - NCW'(1));
    assign active  = (n_use >= NCW'(2)) && (row_reg < last);
    assign room    = (col_reg < last) ? (last - col_reg) : '0;
    assign fits    = CW'(incr_reg) <= CW'(room);
    assign col_hop = col_reg + VB'(incr_reg);
    assign free    = !out_valid_reg || result.ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (q_valid && !q_restart && !finished_reg)
                    state_next = B_WALK;
            end
            B_WALK:
            begin
                // each cycle lands in this row, waits, or rolls to the next
                if ((!active || fits) && free)
                    state_next = B_IDLE;
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_comb
    begin
        q_ready              = (state_reg == B_IDLE);
        result.valid         = out_valid_reg;
        result.source_vertex = src_reg;
        result.target_vertex = tgt_reg;
        result.edge_found    = edge_reg;
        result.done_res      = done_reg;
    end

    always_comb
    begin
        row_next       = row_reg;
        col_next       = col_reg;
        finished_next  = finished_reg;
        incr_next      = incr_reg;
        out_valid_next = out_valid_reg && !result.ready;
        src_next       = src_reg;
        tgt_next       = tgt_reg;
        edge_next      = edge_reg;
        done_next      = done_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (q_valid)
                begin
                    if (q_restart)
                    begin
                        row_next      = '0;
                        col_next      = '0;
                        finished_next = 1'b0;
                    end
                    incr_next = q_skip;
                end
            end
            B_WALK:
            begin
                if (!active)
                begin
                    if (free)
                    begin
                        finished_next  = 1'b1;
                        out_valid_next = 1'b1;
                        src_next       = '0;
                        tgt_next       = '0;
                        edge_next      = 1'b0;
                        done_next      = 1'b1;
                    end
                end
                else if (fits)
                begin
                    if (free)
                    begin
                        col_next = col_hop;
                        if (row_reg != col_hop)
                        begin
                            out_valid_next = 1'b1;
                            src_next       = row_reg;
                            tgt_next       = col_hop;
                            edge_next      = 1'b1;
                            done_next      = 1'b0;
                        end
                    end
                end
                else
                begin
                    incr_next = incr_reg - SKIP_BITS'(room);
                    row_next  = row_reg + VB'(1);
                    col_next  = row_reg + VB'(1);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            row_reg       <= '0;
            col_reg       <= '0;
            finished_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            finished_reg  <= finished_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        incr_reg <= incr_next;
        src_reg  <= src_next;
        tgt_reg  <= tgt_next;
        edge_reg <= edge_next;
        done_reg <= done_next;
    end

    a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> $onehot({edge_reg, done_reg}))
        else $error("result is neither a single edge nor done");
    a_edge_order: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && edge_reg) |-> (src_reg < tgt_reg))
        else $error("edge outside the upper triangle");
    a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_IDLE && q_valid && q_restart) |=> (!finished_reg && row_reg == '0))
        else $error("restart did not clear the cursor");
    a_cursor_order: assert property (@(posedge clk) disable iff (!rst_n)
        row_reg <= col_reg)
        else $error("cursor column behind its row");

endmodule

/* hw/rtl/er_graph_skip_edge_generator_unit.sv */
// Erdos-Renyi skip edge generator. Each sample item carries a uniform Q0.32
// fraction that is turned into a geometric skip and walks an upper-triangle
// cursor over vertex pairs; an edge comes out when the cursor lands, a final
// done result when it runs past the last row. A restart item clears the cursor
// and gives no result. The front end accepts a sample, normalises 2^32-u by
// shifting out its leading zeros, takes log2 with the 32x32 squaring
// multiplier, turns it into a natural log, scales and rounds it, then hands the
// skip over; restarts and short skips (fraction below the edge probability, or
// zero) go straight to the hand-over. The back end walks the skip row by row,
// so long skips over short rows cost extra. A two-entry queue sits between the
// two, so the front end can work on the next sample while the back end is still
// walking rows or the result register waits to be taken.
module er_graph_skip_edge_generator_unit #(
    parameter int VERTEX_BITS = 20,
    parameter int SKIP_BITS   = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [erskip_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [erskip_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    erskip_sample_if.sink                        sample,
    erskip_result_if.source                      result
);
    import erskip_pkg::*;

    logic [NUMV_BITS-1:0] num_vertices_reg;
    logic [31:0]          edge_probability_reg;
    logic [31:0]          skip_scale_reg;

    logic                 push_valid, push_ready, push_restart;
    logic [SKIP_BITS-1:0] push_skip;
    logic                 q_valid, q_ready;
    logic [SKIP_BITS:0]   q_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_vertices_reg     <= '0;
            edge_probability_reg <= '0;
            skip_scale_reg       <= SKIP_SCALE_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_NUM_VERTICES:     num_vertices_reg     <= cfg_data[NUMV_BITS-1:0];
                REG_EDGE_PROBABILITY: edge_probability_reg <= cfg_data[31:0];
                REG_SKIP_SCALE:       skip_scale_reg       <= cfg_data[31:0];
                default: ;
            endcase
        end
    end

    erskip_front #(
        .SKIP_BITS (SKIP_BITS)
    ) u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .sample           (sample),
        .edge_probability (edge_probability_reg),
        .skip_scale       (skip_scale_reg),
        .push_valid       (push_valid),
        .push_ready       (push_ready),
        .push_restart     (push_restart),
        .push_skip        (push_skip)
    );

    erskip_queue #(
        .WIDTH (SKIP_BITS + 1)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (push_valid),
        .wr_ready (push_ready),
        .wr_data  ({push_restart, push_skip}),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_data  (q_data)
    );

    erskip_back #(
        .VERTEX_BITS (VERTEX_BITS),
        .SKIP_BITS   (SKIP_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_ready      (q_ready),
        .q_restart    (q_data[SKIP_BITS]),
        .q_skip       (q_data[SKIP_BITS-1:0]),
        .num_vertices (num_vertices_reg),
        .result       (result)
    );

endmodule

/* verif/er_graph_skip_edge_generator_unit_test.sv */
`timescale 1ns / 100ps

module er_graph_skip_edge_generator_unit_test;

    import erskip_pkg::*;

    localparam int VERTEX_BITS  = 20;
    localparam int SKIP_BITS    = 32;
    localparam int RANDOM_ITEMS = 1200;
    localparam int SETTLE       = 200;
    localparam int CYCLE_LIMIT  = 4000000;

    typedef struct packed {
        logic [VERTEX_BITS-1:0] source_vertex;
        logic [VERTEX_BITS-1:0] target_vertex;
        logic                   edge_found;
        logic                   done_res;
    } pair_result_t;

    typedef struct {
        bit                        is_cfg;
        logic [CFG_INDEX_BITS-1:0] index;
        logic [CFG_DATA_BITS-1:0]  data;
        logic                      operation;
        logic [FRAC_BITS-1:0]      fraction;
        bit                        typed;
        bit                        typed_has;
        pair_result_t              typed_res;
    } stim_row_t;

    logic clk;
    logic rst_n;
    logic cfg_write;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;

    erskip_sample_if sample_ch ();
    erskip_result_if #(.VERTEX_BITS(VERTEX_BITS)) result_ch ();

    er_graph_skip_edge_generator_unit #(
        .VERTEX_BITS(VERTEX_BITS),
        .SKIP_BITS  (SKIP_BITS)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .sample   (sample_ch),
        .result   (result_ch)
    );

    // predictor copy of the configuration and cursor
    logic [63:0] vertex_count;
    logic [63:0] probability;
    logic [63:0] scale;
    logic [63:0] row_pos;
    logic [63:0] col_pos;
    bit          exhausted;

    pair_result_t pending_edges[$];
    stim_row_t    directed_rows[$];
    int  mismatches;
    bit  steady;
    bit  long_hold_req;
    int  hold_left;
    longint cycle_count;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [63:0] neg_ln_q824(logic [31:0] frac);
        logic [63:0] x;
        logic [63:0] mq;
        logic [63:0] bits_acc;
        logic [63:0] lg;
        int          e;
        x = 64'h1_0000_0000 - {32'd0, frac};
        bits_acc = 0;
        if (x >= 64'h1_0000_0000)
            return 64'd0;
        e = 31;
        while (e > 0 && x[e] == 1'b0)
            e--;
        mq = x << (31 - e);
        for (int i = 0; i < LOG_STEPS; i++)
        begin
            mq = (mq * mq) >> 31;
            bits_acc = bits_acc << 1;
            if (mq >= 64'h1_0000_0000)
            begin
                bits_acc[0] = 1'b1;
                mq = mq >> 1;
            end
        end
        lg = (64'(32 - e) << 24) - bits_acc;
        return (lg * {32'd0, LN2_Q32} + 64'h8000_0000) >> 32;
    endfunction

    function automatic logic [63:0] skip_length(logic [31:0] frac);
        logic [63:0] prod;
        logic [63:0] s;
        logic [63:0] maxv;
        maxv = (64'd1 << SKIP_BITS) - 1;
        if ({32'd0, frac} < probability)
            return 64'd1;
        prod = neg_ln_q824(frac) * scale;
        s = (prod >> 40) + ((prod[39:0] != 0) ? 64'd1 : 64'd0);
        if (s > maxv)
            s = maxv;
        if (s == 0)
            s = 1;
        return s;
    endfunction

    function automatic bit advance_cursor(logic op, logic [31:0] frac,
                                          output pair_result_t res);
        logic [63:0] n;
        logic [63:0] last;
        logic [63:0] incr;
        logic [63:0] room;
        res = '0;
        if (op == OP_RESTART)
        begin
            row_pos = 0;
            col_pos = 0;
            exhausted = 1'b0;
            return 1'b0;
        end
        if (exhausted)
            return 1'b0;
        n = vertex_count;
        if (n > (64'd1 << VERTEX_BITS))
            n = 64'd1 << VERTEX_BITS;
        incr = skip_length(frac);
        last = (n >= 1) ? n - 1 : 0;
        while (n >= 2 && row_pos < last)
        begin
            room = (col_pos < last) ? last - col_pos : 0;
            if (incr <= room)
            begin
                col_pos = col_pos + incr;
                if (row_pos != col_pos)
                begin
                    res.source_vertex = row_pos[VERTEX_BITS-1:0];
                    res.target_vertex = col_pos[VERTEX_BITS-1:0];
                    res.edge_found = 1'b1;
                    return 1'b1;
                end
                return 1'b0;
            end
            incr = incr - room;
            row_pos = row_pos + 1;
            col_pos = row_pos;
        end
        exhausted = 1'b1;
        res.done_res = 1'b1;
        return 1'b1;
    endfunction

    task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        case (idx)
            REG_NUM_VERTICES:     vertex_count = {43'd0, value[NUMV_BITS-1:0]};
            REG_EDGE_PROBABILITY: probability  = {32'd0, value};
            REG_SKIP_SCALE:       scale        = {32'd0, value};
            default: ;
        endcase
    endtask

    // wait until every expected result is out, then let any silent item finish
    task automatic drain;
        sample_ch.valid <= 1'b0;
        while (pending_edges.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // returns at the edge where the item is taken
    task automatic send_item(logic op, logic [31:0] frac, bit typed, bit typed_has,
                             pair_result_t typed_res);
        pair_result_t res;
        bit           has;
        if (!steady && $urandom_range(0, 99) < 9)
        begin
            sample_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        sample_ch.valid           <= 1'b1;
        sample_ch.operation       <= op;
        sample_ch.random_fraction <= frac;
        do
            @(posedge clk);
        while (!sample_ch.ready);
        has = advance_cursor(op, frac, res);
        if (typed)
        begin
            has = typed_has;
            res = typed_res;
        end
        if (has)
            pending_edges.push_back(res);
    endtask

    task automatic add_row(bit is_cfg, logic [CFG_INDEX_BITS-1:0] idx,
                           logic [CFG_DATA_BITS-1:0] value, logic op, logic [31:0] frac,
                           bit typed, bit typed_has, logic [19:0] src, logic [19:0] tgt,
                           logic ef, logic dn);
        stim_row_t r;
        r.is_cfg    = is_cfg;
        r.index     = idx;
        r.data      = value;
        r.operation = op;
        r.fraction  = frac;
        r.typed     = typed;
        r.typed_has = typed_has;
        r.typed_res = '{src, tgt, ef, dn};
        directed_rows.push_back(r);
    endtask

    // result side: random back-pressure plus one long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
            hold_left <= 0;
        end
        else if (long_hold_req && hold_left == 0)
        begin
            result_ch.ready <= 1'b0;
            hold_left <= 400;
        end
        else if (hold_left > 1)
        begin
            result_ch.ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else
        begin
            if (hold_left == 1)
                hold_left <= -1;
            result_ch.ready <= steady || ($urandom_range(0, 99) >= 9);
        end
    end

    always @(posedge clk)
    begin
        pair_result_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (pending_edges.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result src=%0d tgt=%0d edge=%0b done=%0b",
                             result_ch.source_vertex, result_ch.target_vertex,
                             result_ch.edge_found, result_ch.done_res);
            end
            else
            begin
                want = pending_edges.pop_front();
                if (result_ch.source_vertex !== want.source_vertex
                    || result_ch.target_vertex !== want.target_vertex
                    || result_ch.edge_found !== want.edge_found
                    || result_ch.done_res !== want.done_res)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp src=%0d tgt=%0d edge=%0b done=%0b got src=%0d tgt=%0d edge=%0b done=%0b",
                                 want.source_vertex, want.target_vertex, want.edge_found,
                                 want.done_res, result_ch.source_vertex,
                                 result_ch.target_vertex, result_ch.edge_found,
                                 result_ch.done_res);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        int           taken;
        int           phase_items;
        int           pick;
        logic [31:0]  frac;
        logic [31:0]  nv;
        logic [31:0]  pv;
        logic [31:0]  sv;
        logic         op;
        stim_row_t    r;

        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        sample_ch.valid = 1'b0;
        sample_ch.operation = OP_CONSUME;
        sample_ch.random_fraction = '0;
        mismatches = 0;
        steady = 1'b0;
        long_hold_req = 1'b0;
        cycle_count = 0;
        vertex_count = 0;
        probability = 0;
        scale = {32'd0, SKIP_SCALE_RESET};
        row_pos = 0;
        col_pos = 0;
        exhausted = 1'b0;

        // no vertices: done straight after reset, then silence until restart
        add_row(0, '0, '0, OP_CONSUME, 32'd0, 1, 1, 0, 0, 0, 1);
        add_row(0, '0, '0, OP_CONSUME, 32'd5, 1, 0, 0, 0, 0, 0);
        add_row(0, '0, '0, OP_RESTART, 32'hFFFF_FFFF, 1, 0, 0, 0, 0, 0);
        add_row(1, REG_NUM_VERTICES, 32'd1, OP_CONSUME, 0, 0, 0, 0, 0, 0, 0);
        add_row(0, '0, '0, OP_CONSUME, 32'h1234_5678, 1, 1, 0, 0, 0, 1);
        add_row(0, '0, '0, OP_RESTART, 32'd0, 1, 0, 0, 0, 0, 0);
        add_row(1, REG_NUM_VERTICES, 32'd5, OP_CONSUME, 0, 0, 0, 0, 0, 0, 0);
        add_row(1, REG_EDGE_PROBABILITY, 32'd0, OP_CONSUME, 0, 0, 0, 0, 0, 0, 0);
        // zero fraction gives zero log, skip raised to one
        add_row(0, '0, '0, OP_CONSUME, 32'd0, 1, 1, 0, 1, 1, 0);
        add_row(0, '0, '0, OP_CONSUME, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0);
        add_row(0, '0, '0, OP_RESTART, 32'd0, 1, 0, 0, 0, 0, 0);
        add_row(1, REG_SKIP_SCALE, 32'd0, OP_CONSUME, 0, 0, 0, 0, 0, 0, 0);
        add_row(0, '0, '0, OP_CONSUME, 32'h8000_0000, 1, 1, 0, 1, 1, 0);
        add_row(1, REG_SKIP_SCALE, 32'hFFFF_FFFF, OP_CONSUME, 0, 0, 0, 0, 0, 0, 0);
        add_row(0, '0, '0, OP_CONSUME, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0);
        add_row(0, '0, '0, OP_RESTART, 32'd0, 1, 0, 0, 0, 0, 0);
        // shrink the row count while the cursor sits past its end
        add_row(1, REG_NUM_VERTICES, 32'd20, OP_CONSUME, 0, 0, 0, 0, 0, 0, 0);
        add_row(1, REG_SKIP_SCALE, 32'd655360, OP_CONSUME, 0, 0, 0, 0, 0, 0, 0);
        add_row(0, '0, '0, OP_CONSUME, 32'h8000_0000, 0, 0, 0, 0, 0, 0);
        add_row(1, REG_NUM_VERTICES, 32'd5, OP_CONSUME, 0, 0, 0, 0, 0, 0, 0);
        add_row(0, '0, '0, OP_CONSUME, 32'h8000_0000, 0, 0, 0, 0, 0, 0);
        add_row(1, REG_NUM_VERTICES, 32'h001F_FFFF, OP_CONSUME, 0, 0, 0, 0, 0, 0, 0);
        add_row(1, REG_EDGE_PROBABILITY, 32'hFFFF_FFFF, OP_CONSUME, 0, 0, 0, 0, 0, 0, 0);
        add_row(0, '0, '0, OP_RESTART, 32'd0, 1, 0, 0, 0, 0, 0);
        add_row(0, '0, '0, OP_CONSUME, 32'd0, 1, 1, 0, 1, 1, 0);
        add_row(0, '0, '0, OP_CONSUME, 32'hFFFF_FFFE, 1, 1, 0, 2, 1, 0);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            r = directed_rows[i];
            if (r.is_cfg)
            begin
                drain();
                write_reg(r.index, r.data);
                cfg_write <= 1'b0;
            end
            else
                send_item(r.operation, r.fraction, r.typed, r.typed_has, r.typed_res);
        end

        taken = 0;
        while (taken < RANDOM_ITEMS)
        begin
            drain();
            pick = $urandom_range(0, 99);
            if (pick < 6)
                nv = $urandom_range(0, 1);
            else if (pick < 10)
                nv = 32'h001F_FFFF;
            else if (pick < 14)
                nv = 32'h0010_0000 - $urandom_range(0, 3);
            else if (pick < 25)
                nv = $urandom_range(2, 3000);
            else
                nv = $urandom_range(2, 60);
            pick = $urandom_range(0, 9);
            pv = (pick == 0) ? 32'd0 : (pick == 1) ? 32'hFFFF_FFFF :
                 (pick < 5) ? $urandom() : ($urandom() >> $urandom_range(1, 31));
            pick = $urandom_range(0, 9);
            sv = (pick == 0) ? 32'd0 : (pick == 1) ? 32'hFFFF_FFFF :
                 (pick < 4) ? $urandom() : 32'd65536 * $urandom_range(1, 16);
            write_reg(REG_NUM_VERTICES, nv);
            write_reg(REG_EDGE_PROBABILITY, pv);
            write_reg(REG_SKIP_SCALE, sv);
            cfg_write <= 1'b0;
            if (taken > 0 && !long_hold_req)
                long_hold_req = 1'b1;
            steady = (taken >= 400 && taken < 600);
            phase_items = (nv >= 32'h000F_0000) ? $urandom_range(5, 12) :
                          $urandom_range(20, 60);
            for (int k = 0; k < phase_items; k++)
            begin
                op = ($urandom_range(0, 99) < 12) ? OP_RESTART : OP_CONSUME;
                pick = $urandom_range(0, 99);
                if (pick < 60)
                    frac = $urandom();
                else if (pick < 75)
                    frac = $urandom() >> $urandom_range(1, 31);
                else if (pick < 90)
                    frac = ~($urandom() >> $urandom_range(1, 31));
                else if (pick < 94)
                    frac = 32'd0;
                else if (pick < 97)
                    frac = 32'hFFFF_FFFF;
                else
                    frac = pv + $urandom_range(0, 2) - 1;
                send_item(op, frac, 0, 0, '0);
                taken++;
            end
        end

        steady = 1'b0;
        drain();
        if (mismatches == 0 && pending_edges.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
